/* sv/tsc_pkg.sv */
// Shared types, codes and constants of the token scanner.
package tsc_pkg;

   localparam int NAME_LIMIT_DEFAULT  = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_IDENT  = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;

   localparam logic [3:0] KIND_EOF     = 4'd0;
   localparam logic [3:0] KIND_PLUS    = 4'd1;
   localparam logic [3:0] KIND_TIMES   = 4'd2;
   localparam logic [3:0] KIND_LPAREN  = 4'd3;
   localparam logic [3:0] KIND_RPAREN  = 4'd4;
   localparam logic [3:0] KIND_IDENT   = 4'd5;
   localparam logic [3:0] KIND_KEYWORD = 4'd6;
   localparam logic [3:0] KIND_NUMBER  = 4'd7;
   localparam logic [3:0] KIND_NULL    = 4'd8;

   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_TIMES  = 8'h2A;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   localparam logic CSR_KEYWORD_TEXT   = 1'b0;
   localparam logic CSR_KEYWORD_LENGTH = 1'b1;

   localparam logic [63:0] KEYWORD_TEXT_RESET   = 64'd435744764535;
   localparam logic [3:0]  KEYWORD_LENGTH_RESET = 4'd5;

   // One queue entry: the token being flushed, if any, and the single-character token.
   typedef struct packed {
      logic [1:0]  pend_mode;
      logic [63:0] text;
      logic [3:0]  count;
      logic [31:0] number;
      logic        overflow;
      logic        tok_valid;
      logic [3:0]  tok_kind;
   } entry_type;

   // Handshake between the front and the queue, and between the queue and the back.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

/* sv/tsc_front.sv */
// Front part of the token scanner: accepts characters, tracks runs and classifies tokens.
module tsc_front #(
   parameter int NAME_LIMIT = tsc_pkg::NAME_LIMIT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // char_code
   input  logic               req_tuser,   // end_of_input
   input  logic               queue_ready,
   output tsc_pkg::push_type  push
);

   logic [1:0]  mode_ff, mode_in;
   logic [63:0] buf_ff, buf_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;

   logic               accept;
   logic               letter;
   logic               digit;
   logic [3:0]         digit_value;
   logic [35:0]        acc_wide;
   logic [35:0]        acc_next;
   tsc_pkg::entry_type entry;

   assign req_tready = queue_ready;
   assign accept     = req_tvalid && req_tready;

   assign letter = req_tdata inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   assign digit  = req_tdata inside {[tsc_pkg::CHAR_ZERO:8'h39]};
   assign digit_value = 4'(req_tdata - tsc_pkg::CHAR_ZERO);

   assign acc_wide = {4'b0, acc_ff};
   assign acc_next = (acc_wide << 3) + (acc_wide << 1) + {32'b0, digit_value};

   always_comb begin
      mode_in  = mode_ff;
      buf_in   = buf_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      entry    = '0;
      if (req_tuser || !(((mode_ff == tsc_pkg::MODE_IDENT) && (letter || digit)) ||
                         ((mode_ff == tsc_pkg::MODE_NUMBER) && digit))) begin
         // The pending run ends here and is handed on.
         if ((mode_ff == tsc_pkg::MODE_IDENT) || (mode_ff == tsc_pkg::MODE_NUMBER)) begin
            entry.pend_mode = mode_ff;
         end
         entry.text     = buf_ff;
         entry.count    = count_ff;
         entry.number   = acc_ff;
         entry.overflow = ovf_ff;
         mode_in  = tsc_pkg::MODE_IDLE;
         buf_in   = '0;
         count_in = '0;
         acc_in   = '0;
         ovf_in   = 1'b0;
         if (req_tuser) begin
            entry.tok_valid = 1'b1;
            entry.tok_kind  = tsc_pkg::KIND_EOF;
         end else if (req_tdata <= tsc_pkg::CHAR_SPACE) begin
            entry.tok_valid = 1'b0;
         end else if (req_tdata == tsc_pkg::CHAR_PLUS) begin
            entry.tok_valid = 1'b1;
            entry.tok_kind  = tsc_pkg::KIND_PLUS;
         end else if (req_tdata == tsc_pkg::CHAR_TIMES) begin
            entry.tok_valid = 1'b1;
            entry.tok_kind  = tsc_pkg::KIND_TIMES;
         end else if (req_tdata == tsc_pkg::CHAR_LPAREN) begin
            entry.tok_valid = 1'b1;
            entry.tok_kind  = tsc_pkg::KIND_LPAREN;
         end else if (req_tdata == tsc_pkg::CHAR_RPAREN) begin
            entry.tok_valid = 1'b1;
            entry.tok_kind  = tsc_pkg::KIND_RPAREN;
         end else if (letter) begin
            mode_in  = tsc_pkg::MODE_IDENT;
            buf_in   = {56'b0, req_tdata};
            count_in = 4'd1;
         end else if (digit) begin
            mode_in = tsc_pkg::MODE_NUMBER;
            acc_in  = {28'b0, digit_value};
         end else begin
            entry.tok_valid = 1'b1;
            entry.tok_kind  = tsc_pkg::KIND_NULL;
         end
      end else if (mode_ff == tsc_pkg::MODE_IDENT) begin
         if (count_ff < 4'(NAME_LIMIT)) begin
            for (int i = 0; i < 8; i++) begin
               if (count_ff[2:0] == 3'(i)) begin
                  buf_in[8*i +: 8] = req_tdata;
               end
            end
            count_in = count_ff + 4'd1;
         end
      end else begin
         acc_in = acc_next[31:0];
         if (acc_next[35:32] != 4'b0) begin
            ovf_in = 1'b1;
         end
      end
   end

   assign push.valid = accept && ((entry.pend_mode != tsc_pkg::MODE_IDLE) || entry.tok_valid);
   assign push.entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tsc_pkg::MODE_IDLE;
         buf_ff   <= '0;
         count_ff <= '0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         buf_ff   <= buf_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

/* sv/tsc_queue.sv */
// Short queue of classified token entries between the front and the back.
module tsc_queue #(
   parameter int DEPTH = tsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  tsc_pkg::push_type push,
   output logic              push_ready,
   output tsc_pkg::head_type head,
   input  logic              pop
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   tsc_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != COUNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && push_ready;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/tsc_back.sv */
// Back part of the token scanner: keyword registers, keyword match and result output register.
module tsc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [63:0]       csr_data,
   input  tsc_pkg::head_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [103:0]      rsp_tdata,   // number_value, number_overflow, ident_text,
                                          // ident_length, zero fill
   output logic              rsp_tlast,   // last_result
   output logic [3:0]        rsp_tuser    // token_kind
);

   logic [63:0] kw_text_ff;
   logic [3:0]  kw_len_ff;

   logic        second_ff, second_in;
   logic        valid_ff, valid_in;
   logic [3:0]  kind_ff, kind_in;
   logic [31:0] num_ff, num_in;
   logic        ovf_ff, ovf_in;
   logic [63:0] text_ff, text_in;
   logic [3:0]  len_ff, len_in;
   logic        last_ff, last_in;

   logic        load;
   logic        emit_first;
   logic [63:0] kw_mask;
   logic        kw_match;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_text_ff <= tsc_pkg::KEYWORD_TEXT_RESET;
         kw_len_ff  <= tsc_pkg::KEYWORD_LENGTH_RESET;
      end else if (csr_valid) begin
         if (csr_index == tsc_pkg::CSR_KEYWORD_TEXT) begin
            kw_text_ff <= csr_data;
         end else begin
            kw_len_ff <= csr_data[3:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         kw_mask[8*i +: 8] = (4'(i) < kw_len_ff) ? 8'hFF : 8'h00;
      end
   end

   assign kw_match = (kw_len_ff != 4'd0) && (kw_len_ff <= 4'd8) &&
                     (head.entry.count == kw_len_ff) &&
                     (((head.entry.text ^ kw_text_ff) & kw_mask) == 64'b0);

   assign load       = !valid_ff || rsp_tready;
   assign emit_first = (head.entry.pend_mode != tsc_pkg::MODE_IDLE) && !second_ff;

   always_comb begin
      second_in = second_ff;
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      num_in    = num_ff;
      ovf_in    = ovf_ff;
      text_in   = text_ff;
      len_in    = len_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = head.valid;
         if (head.valid) begin
            num_in  = '0;
            ovf_in  = 1'b0;
            text_in = '0;
            len_in  = '0;
            if (emit_first) begin
               last_in = !head.entry.tok_valid;
               if (head.entry.pend_mode == tsc_pkg::MODE_IDENT) begin
                  kind_in = kw_match ? tsc_pkg::KIND_KEYWORD : tsc_pkg::KIND_IDENT;
                  text_in = head.entry.text;
                  len_in  = head.entry.count;
               end else begin
                  kind_in = tsc_pkg::KIND_NUMBER;
                  num_in  = head.entry.number;
                  ovf_in  = head.entry.overflow;
               end
               if (head.entry.tok_valid) begin
                  second_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               kind_in   = head.entry.tok_kind;
               last_in   = 1'b1;
               second_in = 1'b0;
               pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      num_ff  <= num_in;
      ovf_ff  <= ovf_in;
      text_ff <= text_in;
      len_ff  <= len_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b0, len_ff, text_ff, ovf_ff, num_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;

endmodule

/* sv/token_scanner_top.sv */
// Top level of the token scanner: front, token queue and back.
//
// The scanner takes one character item per cycle on the req channel while req_tready
// is high and gives each token as one item on the rsp channel. A token passes through
// the queue and then the rsp output register. A character item gives zero, one or two
// tokens; the back moves one token per cycle into the rsp output register while
// rsp_tready is high, so a character that ends a run and also forms a token of its
// own gives its second token in the cycle after the first. The queue of QUEUE_DEPTH
// entries absorbs the difference, and req_tready is low while the queue is full.
// The keyword registers are written through the csr channel, which is always ready.
module token_scanner_top #(
   parameter int NAME_LIMIT  = tsc_pkg::NAME_LIMIT_DEFAULT,
   parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // char_code
   input  logic         req_tuser,   // end_of_input
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // number_value, number_overflow, ident_text,
                                     // ident_length, zero fill
   output logic         rsp_tlast,   // last_result
   output logic [3:0]   rsp_tuser,   // token_kind
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [63:0]  csr_data
);

   tsc_pkg::push_type push;
   tsc_pkg::head_type head;
   logic              queue_ready;
   logic              pop;

   tsc_front #(
      .NAME_LIMIT(NAME_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_ready(queue_ready),
      .push       (push)
   );

   tsc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ready(queue_ready),
      .head      (head),
      .pop       (pop)
   );

   tsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .head      (head),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

/* sv/tsc_checker.sv */
// Port-level checker for the token scanner, bound to the top level.
module tsc_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic         rsp_tlast,
   input logic [3:0]   rsp_tuser
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("Stalled result item changed.");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == tsc_pkg::KIND_EOF)) |-> rsp_tlast)
      else $error("End-of-input token is not the last result of its item.");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= tsc_pkg::KIND_NULL))
      else $error("Token kind out of range.");

   a_ident_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != tsc_pkg::KIND_IDENT) &&
       (rsp_tuser != tsc_pkg::KIND_KEYWORD)) |-> (rsp_tdata[100:33] == 68'b0))
      else $error("Identifier fields set on a non-identifier token.");

endmodule

bind token_scanner_top tsc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast),
   .rsp_tuser (rsp_tuser)
);

/* bench/token_scanner_top_tb.sv */
// Self-checking testbench for token_scanner_top: directed and random character streams.
module token_scanner_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] ch;
      logic       eof;
      logic       typed;
      int         n;
      logic [3:0] kind;
   } row_type;

   typedef struct {
      logic [3:0]  kind;
      logic [31:0] value;
      logic        wrapped;
      logic [63:0] text;
      logic [3:0]  length;
      logic        last;
   } token_type;

   localparam int DIRECTED_ROWS = 26;
   localparam int SETTLE_CYCLES = 16;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tlast;
   logic [3:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = 1'b0;
   logic [63:0]  csr_data = 64'd0;

   token_scanner_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Scanner state and keyword registers as the block should hold them.
   logic [1:0]  lex_mode    = tsc_pkg::MODE_IDLE;
   logic [63:0] id_chars    = 64'd0;
   logic [3:0]  id_count    = 4'd0;
   logic [31:0] num_acc     = 32'd0;
   logic        num_wrapped = 1'b0;
   logic [63:0] kw_text     = tsc_pkg::KEYWORD_TEXT_RESET;
   logic [3:0]  kw_len      = tsc_pkg::KEYWORD_LENGTH_RESET;

   token_type step_tokens[$];
   token_type tokens_due[$];
   row_type   script[$];
   int        errors = 0;
   int        items_accepted = 0;
   bit        holdoff_done = 1'b0;

   row_type directed [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, 1, tsc_pkg::KIND_EOF},
      '{8'h00, 1'b0, 1'b1, 0, tsc_pkg::KIND_EOF},
      '{tsc_pkg::CHAR_SPACE, 1'b0, 1'b1, 0, tsc_pkg::KIND_EOF},
      '{tsc_pkg::CHAR_PLUS, 1'b0, 1'b1, 1, tsc_pkg::KIND_PLUS},
      '{tsc_pkg::CHAR_TIMES, 1'b0, 1'b1, 1, tsc_pkg::KIND_TIMES},
      '{tsc_pkg::CHAR_LPAREN, 1'b0, 1'b1, 1, tsc_pkg::KIND_LPAREN},
      '{tsc_pkg::CHAR_RPAREN, 1'b0, 1'b1, 1, tsc_pkg::KIND_RPAREN},
      '{8'hFF, 1'b0, 1'b1, 1, tsc_pkg::KIND_NULL},
      '{8'h80, 1'b0, 1'b1, 1, tsc_pkg::KIND_NULL},
      '{"w", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"r", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"i", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"t", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"e", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{tsc_pkg::CHAR_SPACE, 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"A", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"9", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"z", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{tsc_pkg::CHAR_PLUS, 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"0", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"9", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{tsc_pkg::CHAR_RPAREN, 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"Z", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"@", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{"5", 1'b0, 1'b0, 0, tsc_pkg::KIND_EOF},
      '{8'hFF, 1'b1, 1'b0, 0, tsc_pkg::KIND_EOF}
   };

   function automatic bit is_letter(logic [7:0] c);
      return c inside {["A":"Z"], ["a":"z"]};
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic void emit(logic [3:0] kind, logic [31:0] value, logic wrapped,
                                logic [63:0] text, logic [3:0] length);
      token_type t;
      t = '{kind, value, wrapped, text, length, 1'b0};
      step_tokens.push_back(t);
   endfunction

   function automatic bit keyword_hit();
      logic [63:0] mask;
      if (kw_len == 4'd0 || kw_len > 4'd8 || id_count != kw_len) return 1'b0;
      mask = (kw_len == 4'd8) ? '1 : ((64'd1 << (8 * kw_len)) - 64'd1);
      return id_chars == (kw_text & mask);
   endfunction

   function automatic void add_digit(logic [7:0] c);
      logic [35:0] t;
      t = 36'(num_acc) * 36'd10 + 36'(c - tsc_pkg::CHAR_ZERO);
      if (t[35:32] != 4'd0) num_wrapped = 1'b1;
      num_acc = t[31:0];
   endfunction

   function automatic void flush_token();
      if (lex_mode == tsc_pkg::MODE_IDENT)
         emit(keyword_hit() ? tsc_pkg::KIND_KEYWORD : tsc_pkg::KIND_IDENT, 32'd0, 1'b0,
              id_chars, id_count);
      else if (lex_mode == tsc_pkg::MODE_NUMBER)
         emit(tsc_pkg::KIND_NUMBER, num_acc, num_wrapped, 64'd0, 4'd0);
      lex_mode = tsc_pkg::MODE_IDLE;
      id_chars = 64'd0;
      id_count = 4'd0;
      num_acc = 32'd0;
      num_wrapped = 1'b0;
   endfunction

   // Advances the scanner state by one item and leaves its tokens in step_tokens.
   function automatic void lex_char(logic [7:0] c, logic eof);
      step_tokens.delete();
      if (eof) begin
         flush_token();
         emit(tsc_pkg::KIND_EOF, 32'd0, 1'b0, 64'd0, 4'd0);
      end else begin
         if (lex_mode == tsc_pkg::MODE_IDENT) begin
            if (is_letter(c) || is_digit(c)) begin
               if (id_count < tsc_pkg::NAME_LIMIT_DEFAULT) begin
                  id_chars[8 * id_count +: 8] = c;
                  id_count++;
               end
               return;
            end
            flush_token();
         end else if (lex_mode == tsc_pkg::MODE_NUMBER) begin
            if (is_digit(c)) begin
               add_digit(c);
               return;
            end
            flush_token();
         end else begin
            lex_mode = tsc_pkg::MODE_IDLE;
         end
         if (c <= tsc_pkg::CHAR_SPACE) begin
         end else if (c == tsc_pkg::CHAR_PLUS) begin
            emit(tsc_pkg::KIND_PLUS, 32'd0, 1'b0, 64'd0, 4'd0);
         end else if (c == tsc_pkg::CHAR_TIMES) begin
            emit(tsc_pkg::KIND_TIMES, 32'd0, 1'b0, 64'd0, 4'd0);
         end else if (c == tsc_pkg::CHAR_LPAREN) begin
            emit(tsc_pkg::KIND_LPAREN, 32'd0, 1'b0, 64'd0, 4'd0);
         end else if (c == tsc_pkg::CHAR_RPAREN) begin
            emit(tsc_pkg::KIND_RPAREN, 32'd0, 1'b0, 64'd0, 4'd0);
         end else if (is_letter(c)) begin
            lex_mode = tsc_pkg::MODE_IDENT;
            id_chars = 64'(c);
            id_count = 4'd1;
         end else if (is_digit(c)) begin
            lex_mode = tsc_pkg::MODE_NUMBER;
            num_acc = 32'd0;
            num_wrapped = 1'b0;
            add_digit(c);
         end else begin
            emit(tsc_pkg::KIND_NULL, 32'd0, 1'b0, 64'd0, 4'd0);
         end
      end
      if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
   endfunction

   function automatic logic [7:0] pick_letter();
      return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
   endfunction

   function automatic logic [7:0] pick_alnum();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(48, 57)) : pick_letter();
   endfunction

   function automatic void add_char(logic [7:0] c, logic eof);
      row_type r;
      r = '{c, eof, 1'b0, 0, tsc_pkg::KIND_EOF};
      script.push_back(r);
   endfunction

   function automatic bit keyword_spellable();
      if (kw_len == 4'd0 || kw_len > 4'd8 || !is_letter(kw_text[7:0])) return 1'b0;
      for (int i = 1; i < kw_len; i++)
         if (!is_letter(kw_text[8 * i +: 8]) && !is_digit(kw_text[8 * i +: 8])) return 1'b0;
      return 1'b1;
   endfunction

   // Mostly well-formed token streams with random content, some noise mixed in.
   function automatic void build_random(int count);
      int start, pick, len;
      start = script.size();
      while (script.size() - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 15 && keyword_spellable()) begin
            len = kw_len;
            case ($urandom_range(0, 3))
               0: len = len - 1;
               1: len = len + $urandom_range(1, 3);
               default: ;
            endcase
            for (int i = 0; i < len; i++)
               add_char((i < kw_len) ? kw_text[8 * i +: 8] : pick_alnum(), 1'b0);
         end else if (pick < 40) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            add_char(pick_letter(), 1'b0);
            for (int i = 1; i < len; i++) add_char(pick_alnum(), 1'b0);
         end else if (pick < 60) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
            for (int i = 0; i < len; i++) add_char(8'($urandom_range(48, 57)), 1'b0);
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0: add_char(tsc_pkg::CHAR_PLUS, 1'b0);
               1: add_char(tsc_pkg::CHAR_TIMES, 1'b0);
               2: add_char(tsc_pkg::CHAR_LPAREN, 1'b0);
               default: add_char(tsc_pkg::CHAR_RPAREN, 1'b0);
            endcase
         end else if (pick < 90) begin
            add_char(8'($urandom_range(0, 32)), 1'b0);
         end else if (pick < 97) begin
            add_char(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            add_char(8'($urandom_range(0, 255)), 1'b1);
         end
      end
      add_char(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   task automatic run_script();
      int burst, gap;
      burst = 0;
      foreach (script[i]) begin
         if (burst == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 24);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= script[i].ch;
         req_tuser  <= script[i].eof;
         do @(posedge clock); while (!req_tready);
         items_accepted++;
         lex_char(script[i].ch, script[i].eof);
         if (script[i].typed) begin
            for (int k = 0; k < script[i].n; k++)
               tokens_due.push_back('{script[i].kind, 32'd0, 1'b0, 64'd0, 4'd0,
                                      k == script[i].n - 1});
         end else begin
            foreach (step_tokens[k]) tokens_due.push_back(step_tokens[k]);
         end
         burst--;
      end
      req_tvalid <= 1'b0;
      script.delete();
   endtask

   task automatic drain();
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] index, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == tsc_pkg::CSR_KEYWORD_TEXT) kw_text = value;
      else kw_len = value[3:0];
      @(posedge clock);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tokens_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual kind %0d data %h",
                     $realtime, rsp_tuser, rsp_tdata);
         end else begin
            want = tokens_due.pop_front();
            check_field("token_kind", want.kind, rsp_tuser);
            check_field("number_value", want.value, rsp_tdata[31:0]);
            check_field("number_overflow", want.wrapped, rsp_tdata[32]);
            check_field("ident_text", want.text, rsp_tdata[96:33]);
            check_field("ident_length", want.length, rsp_tdata[100:97]);
            check_field("last_result", want.last, rsp_tlast);
         end
      end
   end

   initial begin : rsp_stall
      int seg, style;
      forever begin
         if (!holdoff_done && items_accepted >= 600) begin
            holdoff_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         style = $urandom_range(0, 2);
         seg = $urandom_range(16, 96);
         for (int tick = 0; tick < seg; tick++) begin
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= (tick % 4 == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("token_scanner_top test failed");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] text;
      logic [3:0]  len;
      logic [63:0] kw_texts [5];
      logic [3:0]  kw_lens [5];
      kw_texts = '{64'hDEAD_BEEF_0000_6669, 64'h6867_6665_4443_4241,
                   64'hFFFF_FFFF_FFFF_FF78, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h0000_0000_0000_0000};
      kw_lens = '{4'd2, 4'd8, 4'd1, 4'd8, 4'd1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) script.push_back(directed[i]);
      run_script();
      build_random(220);
      run_script();
      drain();
      for (int p = 0; p < 7; p++) begin
         if (p < 5) begin
            text = kw_texts[p];
            len = kw_lens[p];
         end else begin
            len = 4'($urandom_range(1, 8));
            text = {$urandom, $urandom};
            text[7:0] = pick_letter();
            for (int i = 1; i < len; i++) text[8 * i +: 8] = pick_alnum();
         end
         csr_write(tsc_pkg::CSR_KEYWORD_TEXT, text);
         csr_write(tsc_pkg::CSR_KEYWORD_LENGTH, 64'(len));
         build_random(200);
         run_script();
         drain();
      end
      if (errors == 0)
         $display("token_scanner_top test passed");
      else
         $display("token_scanner_top test failed");
      $finish;
   end

endmodule
